### sv/wsfd_pkg.sv
// Package with widths, status codes and the result type of the WebSocket deframer.
`timescale 1ns / 1ps

package wsfd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned OpcodeW = 4;
  localparam int unsigned LenW    = 63;
  localparam int unsigned StatusW = 4;

  localparam logic [LenW-1:0] MaxLenReset = 63'd2147483646;

  // Result status codes; the low five also serve as the per-frame header status.
  localparam logic [StatusW-1:0] StOk          = 4'd0;
  localparam logic [StatusW-1:0] StRsvSet      = 4'd1;
  localparam logic [StatusW-1:0] StOpcodeRsvd  = 4'd2;
  localparam logic [StatusW-1:0] StCtrlLong    = 4'd3;
  localparam logic [StatusW-1:0] StCtrlFrag    = 4'd4;
  localparam logic [StatusW-1:0] StShort16     = 4'd5;
  localparam logic [StatusW-1:0] StTopBit      = 4'd6;
  localparam logic [StatusW-1:0] StShort64     = 4'd7;
  localparam logic [StatusW-1:0] StTooBig      = 4'd8;
  localparam logic [StatusW-1:0] StEmpty       = 4'd9;

  typedef struct packed {
    logic [ByteW-1:0]   payload_byte;
    logic               payload_valid;
    logic               frame_end;
    logic [OpcodeW-1:0] frame_opcode;
    logic               final_fragment;
    logic [LenW-1:0]    frame_length;
    logic [StatusW-1:0] status;
    logic               protocol_ok;
  } result_t;

endpackage

### sv/wsfd_rx_if.sv
// Stream interface that carries one received byte per word.
`timescale 1ns / 1ps

interface wsfd_rx_if import wsfd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### sv/wsfd_frame_if.sv
// Stream interface that carries one deframer result per word.
`timescale 1ns / 1ps

interface wsfd_frame_if import wsfd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ByteW-1:0]   payload_byte;
  logic               payload_valid;
  logic               frame_end;
  logic [OpcodeW-1:0] frame_opcode;
  logic               final_fragment;
  logic [LenW-1:0]    frame_length;
  logic [StatusW-1:0] status;
  logic               protocol_ok;

  modport source (output valid, output payload_byte, output payload_valid, output frame_end,
                  output frame_opcode, output final_fragment, output frame_length,
                  output status, output protocol_ok, input ready);
  modport sink   (input valid, input payload_byte, input payload_valid, input frame_end,
                  input frame_opcode, input final_fragment, input frame_length,
                  input status, input protocol_ok, output ready);
endinterface

### sv/websocket_frame_deframer_top.sv
// WebSocket receive deframer: header parser, payload unmasking and output skid stage.
//
//   Channel   Dir   Handshake          Word
//   rx_if     in    valid/ready        one received byte
//   frame_if  out   valid/ready        one result per byte (payload, end, header, status)
//   cfg       in    cfg_we_i           max_payload_length, 63 bits
//
// One byte is accepted in every cycle while the skid register is empty; its result is
// registered in the output register. The parser state updates in the cycle of acceptance
// from short logic (64-bit compares against the maximum and an XOR). A skid register
// behind the output register lets one more byte in while the output is stalled; ready
// drops only when both hold a word. Reset returns the parser to the first header byte
// and sets the maximum to 2147483646.
`timescale 1ns / 1ps

module websocket_frame_deframer_top import wsfd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_wdata_i,
  wsfd_rx_if.sink         rx_if,
  wsfd_frame_if.source    frame_if
);

  localparam logic [2:0] PhHdr1    = 3'd0;
  localparam logic [2:0] PhHdr2    = 3'd1;
  localparam logic [2:0] PhLen16   = 3'd2;
  localparam logic [2:0] PhLen64   = 3'd3;
  localparam logic [2:0] PhMask    = 3'd4;
  localparam logic [2:0] PhPayload = 3'd5;

  logic [LenW-1:0]    max_len_q;
  logic [2:0]         phase_q, phase_d;
  logic [2:0]         cnt_q, cnt_d;
  logic [63:0]        acc_q, acc_d;
  logic [LenW-1:0]    rem_q, rem_d;
  logic [31:0]        key_q, key_d;
  logic [1:0]         midx_q, midx_d;
  logic [OpcodeW-1:0] op_q, op_d;
  logic               fin_q, fin_d;
  logic               masked_q, masked_d;
  logic [2:0]         hs_q, hs_d;

  logic [ByteW-1:0]   b;
  logic [6:0]         len7;
  logic [ByteW-1:0]   key_byte;
  logic [StatusW-1:0] term;
  logic [ByteW-1:0]   pbyte;
  logic               pvalid;
  logic               fend;
  result_t            res;

  logic    accept;
  logic    out_take;
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;

  // Returns the terminating status when a frame cannot start its payload, else ok.
  function automatic logic [StatusW-1:0] payload_gate(input logic [63:0] len,
                                                      input logic [LenW-1:0] max_len);
    logic [StatusW-1:0] st;
    if (len == 64'd0) begin
      st = StEmpty;
    end else if (len > {1'b0, max_len}) begin
      st = StTooBig;
    end else begin
      st = StOk;
    end
    return st;
  endfunction

  function automatic logic opcode_reserved(input logic [OpcodeW-1:0] op);
    return (op >= 4'd3 && op <= 4'd7) || op >= 4'd11;
  endfunction

  assign b        = rx_if.rx_byte;
  assign len7     = b[6:0];
  assign accept   = rx_if.valid && rx_if.ready;
  assign out_take = out_valid_q && frame_if.ready;
  assign key_byte = key_q[8*(3-midx_q) +: 8];

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    rem_d    = rem_q;
    key_d    = key_q;
    midx_d   = midx_q;
    op_d     = op_q;
    fin_d    = fin_q;
    masked_d = masked_q;
    hs_d     = hs_q;
    term     = StOk;
    pbyte    = '0;
    pvalid   = 1'b0;
    fend     = 1'b0;

    case (phase_q)
      PhHdr1: begin
        fin_d    = b[7];
        op_d     = b[3:0];
        acc_d    = '0;
        masked_d = 1'b0;
        if (|b[6:4]) begin
          hs_d = StRsvSet[2:0];
        end else if (opcode_reserved(b[3:0])) begin
          hs_d = StOpcodeRsvd[2:0];
        end else begin
          hs_d = StOk[2:0];
        end
        phase_d = PhHdr2;
      end
      PhHdr2: begin
        masked_d = b[7];
        acc_d    = {57'd0, len7};
        if (hs_q == StOk[2:0] && op_q[3]) begin
          if (len7 > 7'd125) begin
            hs_d = StCtrlLong[2:0];
          end else if (!fin_q) begin
            hs_d = StCtrlFrag[2:0];
          end
        end
        if (len7 == 7'd126) begin
          phase_d = PhLen16;
          cnt_d   = '0;
          acc_d   = '0;
        end else if (len7 == 7'd127) begin
          phase_d = PhLen64;
          cnt_d   = '0;
          acc_d   = '0;
        end else if (b[7]) begin
          phase_d = PhMask;
          cnt_d   = '0;
          key_d   = '0;
        end else begin
          term = payload_gate({57'd0, len7}, max_len_q);
        end
      end
      PhLen16: begin
        acc_d = {acc_q[55:0], b};
        if (cnt_q >= 3'd1) begin
          if ({acc_q[55:0], b} < 64'd126) begin
            phase_d = PhHdr1;
            term    = StShort16;
          end else if (masked_q) begin
            phase_d = PhMask;
            cnt_d   = '0;
            key_d   = '0;
          end else begin
            term = payload_gate({acc_q[55:0], b}, max_len_q);
          end
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      PhLen64: begin
        acc_d = {acc_q[55:0], b};
        if (cnt_q >= 3'd7) begin
          if (acc_q[55]) begin
            phase_d = PhHdr1;
            term    = StTopBit;
          end else if ({acc_q[55:0], b} <= 64'hFFFF) begin
            phase_d = PhHdr1;
            term    = StShort64;
          end else if (masked_q) begin
            phase_d = PhMask;
            cnt_d   = '0;
            key_d   = '0;
          end else begin
            term = payload_gate({acc_q[55:0], b}, max_len_q);
          end
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      PhMask: begin
        key_d = {key_q[23:0], b};
        if (cnt_q >= 3'd3) begin
          term = payload_gate(acc_q, max_len_q);
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      PhPayload: begin
        pvalid = 1'b1;
        pbyte  = masked_q ? (b ^ key_byte) : b;
        midx_d = midx_q + 2'd1;
        if (rem_q <= 63'd1) begin
          rem_d   = '0;
          fend    = 1'b1;
          phase_d = PhHdr1;
        end else begin
          rem_d = rem_q - 63'd1;
        end
      end
      default: begin
        phase_d = PhHdr1;
      end
    endcase

    // Payload starts only where a gate was evaluated and passed; the gate points are
    // exactly those where the next phase was left unchanged on a completed length or key.
    if (term != StOk) begin
      fend    = 1'b1;
      phase_d = PhHdr1;
    end else if ((phase_q == PhHdr2 && len7 < 7'd126 && !b[7]) ||
                 (phase_q == PhLen16 && cnt_q >= 3'd1 && !masked_q) ||
                 (phase_q == PhLen64 && cnt_q >= 3'd7 && !masked_q) ||
                 (phase_q == PhMask && cnt_q >= 3'd3)) begin
      phase_d = PhPayload;
      rem_d   = acc_d[LenW-1:0];
      midx_d  = '0;
    end
  end

  always_comb begin
    res.payload_byte   = pbyte;
    res.payload_valid  = pvalid;
    res.frame_end      = fend;
    res.frame_opcode   = op_d;
    res.final_fragment = fin_d;
    res.frame_length   = acc_d[LenW-1:0];
    res.status         = (term != StOk) ? term : {1'b0, hs_d};
    res.protocol_ok    = (hs_d == StOk[2:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
      phase_q   <= PhHdr1;
      cnt_q     <= '0;
      acc_q     <= '0;
      rem_q     <= '0;
      key_q     <= '0;
      midx_q    <= '0;
      op_q      <= 4'd8;
      fin_q     <= 1'b1;
      masked_q  <= 1'b0;
      hs_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      if (accept) begin
        phase_q  <= phase_d;
        cnt_q    <= cnt_d;
        acc_q    <= acc_d;
        rem_q    <= rem_d;
        key_q    <= key_d;
        midx_q   <= midx_d;
        op_q     <= op_d;
        fin_q    <= fin_d;
        masked_q <= masked_d;
        hs_q     <= hs_d;
      end
    end
  end

  // Output register with one skid word behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_take) begin
          skid_valid_q <= 1'b0;
        end
      end else if (accept) begin
        if (out_valid_q && !frame_if.ready) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (out_valid_q && !frame_if.ready) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign rx_if.ready             = !skid_valid_q;
  assign frame_if.valid          = out_valid_q;
  assign frame_if.payload_byte   = out_q.payload_byte;
  assign frame_if.payload_valid  = out_q.payload_valid;
  assign frame_if.frame_end      = out_q.frame_end;
  assign frame_if.frame_opcode   = out_q.frame_opcode;
  assign frame_if.final_fragment = out_q.final_fragment;
  assign frame_if.frame_length   = out_q.frame_length;
  assign frame_if.status         = out_q.status;
  assign frame_if.protocol_ok    = out_q.protocol_ok;

endmodule

### tb/websocket_frame_deframer_top_tb.sv
// Self-checking testbench for the WebSocket receive deframer with a byte-level predictor.
`timescale 1ns / 1ps

module websocket_frame_deframer_top_tb;
  import wsfd_pkg::*;

  typedef enum logic [2:0] {
    PhHdr1, PhHdr2, PhLen16, PhLen64, PhMask, PhPayload
  } parse_phase_e;

  localparam int LenForm7  = 0;
  localparam int LenForm16 = 1;
  localparam int LenForm64 = 2;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [LenW-1:0] cfg_wdata_i;

  wsfd_rx_if    rx_bus ();
  wsfd_frame_if frame_bus ();

  websocket_frame_deframer_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_if       (rx_bus),
    .frame_if    (frame_bus)
  );

  // Predictor state, starting from the reset values of the block.
  parse_phase_e        parse_phase    = PhHdr1;
  int                  len_bytes_seen = 0;
  logic [63:0]         len_acc        = '0;
  logic [LenW-1:0]     payload_left   = '0;
  logic [31:0]         key_word       = '0;
  logic [1:0]          key_pos        = '0;
  logic [OpcodeW-1:0]  cur_opcode     = 4'd8;
  logic                cur_fin        = 1'b1;
  logic                cur_masked     = 1'b0;
  logic [StatusW-1:0]  hdr_err        = StOk;
  logic [LenW-1:0]     max_len        = MaxLenReset;

  result_t pending_results[$];
  int      mismatch_count = 0;
  int      bytes_sent     = 0;
  logic    traffic_idle   = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [StatusW-1:0] start_payload();
    if (len_acc == 64'd0) begin
      parse_phase = PhHdr1;
      return StEmpty;
    end
    if (len_acc > {1'b0, max_len}) begin
      parse_phase = PhHdr1;
      return StTooBig;
    end
    parse_phase  = PhPayload;
    payload_left = len_acc[LenW-1:0];
    key_pos      = 2'd0;
    return StOk;
  endfunction

  function automatic logic [StatusW-1:0] finish_length();
    if (cur_masked) begin
      parse_phase    = PhMask;
      len_bytes_seen = 0;
      key_word       = '0;
      return StOk;
    end
    return start_payload();
  endfunction

  function automatic result_t deframe_byte(input logic [7:0] b);
    result_t            r;
    logic [StatusW-1:0] term;
    logic [7:0]         key_byte;
    r    = '0;
    term = StOk;
    case (parse_phase)
      PhHdr1: begin
        cur_fin    = b[7];
        cur_opcode = b[3:0];
        len_acc    = '0;
        cur_masked = 1'b0;
        if (b[6:4] != 3'b000) hdr_err = StRsvSet;
        else if ((b[3:0] >= 4'd3 && b[3:0] <= 4'd7) || b[3:0] >= 4'd11) hdr_err = StOpcodeRsvd;
        else hdr_err = StOk;
        parse_phase = PhHdr2;
      end
      PhHdr2: begin
        cur_masked = b[7];
        len_acc    = {57'd0, b[6:0]};
        // Control frame checks only apply when the first byte was clean.
        if (hdr_err == StOk && cur_opcode[3]) begin
          if (b[6:0] > 7'd125) hdr_err = StCtrlLong;
          else if (!cur_fin) hdr_err = StCtrlFrag;
        end
        if (b[6:0] == 7'd126 || b[6:0] == 7'd127) begin
          parse_phase    = (b[6:0] == 7'd126) ? PhLen16 : PhLen64;
          len_bytes_seen = 0;
          len_acc        = '0;
        end else begin
          term = finish_length();
        end
      end
      PhLen16: begin
        len_acc = {len_acc[55:0], b};
        if (len_bytes_seen >= 1) begin
          if (len_acc < 64'd126) begin
            parse_phase = PhHdr1;
            term        = StShort16;
          end else begin
            term = finish_length();
          end
        end else begin
          len_bytes_seen++;
        end
      end
      PhLen64: begin
        len_acc = {len_acc[55:0], b};
        if (len_bytes_seen >= 7) begin
          if (len_acc[63]) begin
            parse_phase = PhHdr1;
            term        = StTopBit;
          end else if (len_acc <= 64'hFFFF) begin
            parse_phase = PhHdr1;
            term        = StShort64;
          end else begin
            term = finish_length();
          end
        end else begin
          len_bytes_seen++;
        end
      end
      PhMask: begin
        key_word = {key_word[23:0], b};
        if (len_bytes_seen >= 3) term = start_payload();
        else len_bytes_seen++;
      end
      PhPayload: begin
        key_byte        = 8'(key_word >> (8 * (3 - int'(key_pos))));
        r.payload_valid = 1'b1;
        r.payload_byte  = cur_masked ? (b ^ key_byte) : b;
        key_pos++;
        if (payload_left <= 1) begin
          payload_left = '0;
          r.frame_end  = 1'b1;
          parse_phase  = PhHdr1;
        end else begin
          payload_left--;
        end
      end
      default: parse_phase = PhHdr1;
    endcase
    if (term != StOk) r.frame_end = 1'b1;
    r.frame_opcode   = cur_opcode;
    r.final_fragment = cur_fin;
    r.frame_length   = len_acc[LenW-1:0];
    r.status         = (term != StOk) ? term : hdr_err;
    r.protocol_ok    = (hdr_err == StOk);
    return r;
  endfunction

  // Result side: random stall bursts while idling is enabled.
  initial begin : result_stall
    int stall_left;
    stall_left      = 0;
    frame_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        frame_bus.ready <= 1'b0;
      end else if (traffic_idle && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        frame_bus.ready <= 1'b0;
      end else begin
        frame_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : result_check
    result_t got;
    result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && frame_bus.valid && frame_bus.ready) begin
        got = '{payload_byte: frame_bus.payload_byte, payload_valid: frame_bus.payload_valid,
                frame_end: frame_bus.frame_end, frame_opcode: frame_bus.frame_opcode,
                final_fragment: frame_bus.final_fragment, frame_length: frame_bus.frame_length,
                status: frame_bus.status, protocol_ok: frame_bus.protocol_ok};
        if (pending_results.size() == 0) begin
          if (mismatch_count < 10) $display("unexpected result word at %0t", $realtime);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            if (mismatch_count < 10) begin
              $display("mismatch at %0t", $realtime);
              $display("  exp byte=%h pv=%b end=%b op=%h fin=%b len=%h st=%0d ok=%b",
                       want.payload_byte, want.payload_valid, want.frame_end,
                       want.frame_opcode, want.final_fragment, want.frame_length,
                       want.status, want.protocol_ok);
              $display("  got byte=%h pv=%b end=%b op=%h fin=%b len=%h st=%0d ok=%b",
                       got.payload_byte, got.payload_valid, got.frame_end,
                       got.frame_opcode, got.final_fragment, got.frame_length,
                       got.status, got.protocol_ok);
            end
            mismatch_count++;
          end
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (traffic_idle && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      rx_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_bus.valid   <= 1'b1;
    rx_bus.rx_byte <= b;
    do @(posedge clk_i); while (!rx_bus.ready);
    pending_results.insert(pending_results.size(), deframe_byte(b));
    bytes_sent++;
  endtask

  task automatic wait_for_all_results();
    rx_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_max_length(input logic [LenW-1:0] value);
    wait_for_all_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    max_len = value;
  endtask

  // Sends a header and then whatever the parser still needs to close the frame.
  task automatic send_frame(input logic [7:0] first_byte, input logic mask_on,
                            input logic [63:0] len, input int len_form,
                            input logic [31:0] key);
    logic [6:0] code;
    int         n_ext;
    code  = (len_form == LenForm16) ? 7'd126 : (len_form == LenForm64) ? 7'd127 : len[6:0];
    n_ext = (len_form == LenForm16) ? 2 : (len_form == LenForm64) ? 8 : 0;
    send_byte(first_byte);
    send_byte({mask_on, code});
    for (int i = n_ext - 1; i >= 0; i--) send_byte(len[8*i +: 8]);
    for (int i = 3; i >= 0; i--) begin
      if (parse_phase == PhMask) send_byte(key[8*i +: 8]);
    end
    while (parse_phase == PhPayload) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_random_frame();
    logic [7:0]  first_byte;
    logic [63:0] len;
    logic [3:0]  op;
    logic        fin;
    int          pick;
    int          form;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      pick = $urandom_range(0, 5);
      op   = (pick < 3) ? 4'(pick) : 4'(pick + 5);
      fin  = op[3] ? ($urandom_range(0, 9) != 0) : 1'($urandom_range(0, 1));
      first_byte = {fin, 3'b000, op};
    end else begin
      first_byte = 8'($urandom_range(0, 255));
    end
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      form = LenForm7;
      len  = 64'($urandom_range(0, 40));
    end else if (pick < 70) begin
      form = LenForm16;
      len  = 64'($urandom_range(126, 220));
    end else if (pick < 78) begin
      form = LenForm16;
      len  = 64'($urandom_range(0, 125));
    end else if (pick < 86) begin
      form = LenForm64;
      len  = 64'($urandom_range(0, 16'hFFFF));
    end else if (pick < 93) begin
      form = LenForm64;
      len  = {1'b1, 31'($urandom), 32'($urandom)};
    end else begin
      form = LenForm64;
      len  = {1'b0, 31'($urandom), 32'($urandom)};
      // A long frame that would be accepted is folded back into a short one.
      if (len <= {1'b0, max_len}) len = len & 64'hFFFF;
    end
    send_frame(first_byte, $urandom_range(0, 9) < 7, len, form, $urandom);
  endtask

  task automatic test_random_traffic(input int n_bytes);
    int target;
    int n_noise;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      // Stray bytes only while the maximum keeps any resulting payload short.
      if (max_len < 1024 && $urandom_range(0, 9) == 0) begin
        n_noise = $urandom_range(1, 6);
        repeat (n_noise) send_byte(8'($urandom_range(0, 255)));
        while (parse_phase != PhHdr1) send_byte(8'($urandom_range(0, 255)));
      end
      send_random_frame();
    end
  endtask

  task automatic test_basic_frames();
    send_byte(8'h82);
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(8'h81, 1'b1, 64'd5, LenForm7, 32'h37FA213D);
    send_frame(8'h01, 1'b0, 64'd3, LenForm7, 32'h0);
    send_frame(8'h80, 1'b1, 64'd2, LenForm7, 32'hFFFFFFFF);
    send_frame(8'h8A, 1'b1, 64'd4, LenForm7, 32'h00000000);
  endtask

  task automatic test_header_errors();
    send_frame(8'hF1, 1'b0, 64'd1, LenForm7, 32'h0);
    send_frame(8'hC1, 1'b1, 64'd2, LenForm7, 32'h12345678);
    send_frame(8'h83, 1'b0, 64'd1, LenForm7, 32'h0);
    send_frame(8'h8F, 1'b0, 64'd1, LenForm7, 32'h0);
    send_frame(8'h8B, 1'b0, 64'd1, LenForm7, 32'h0);
    // Reserved bits win over a reserved opcode.
    send_frame(8'hB3, 1'b0, 64'd1, LenForm7, 32'h0);
    send_frame(8'h89, 1'b0, 64'd130, LenForm16, 32'h0);
    send_frame(8'h09, 1'b1, 64'd2, LenForm7, 32'hA5A5A5A5);
    // A long control frame is reported before a fragmented one.
    send_frame(8'h08, 1'b0, 64'd126, LenForm16, 32'h0);
    send_frame(8'h88, 1'b1, 64'd2, LenForm7, 32'h01020304);
  endtask

  task automatic test_length_forms();
    send_frame(8'h82, 1'b0, 64'd126, LenForm16, 32'h0);
    send_frame(8'h82, 1'b1, 64'd125, LenForm16, 32'h0);
    send_frame(8'h82, 1'b0, 64'd0, LenForm16, 32'h0);
    send_frame(8'h82, 1'b0, 64'hFFFF, LenForm64, 32'h0);
    send_frame(8'h82, 1'b1, {1'b1, 31'($urandom), 32'($urandom)}, LenForm64, 32'h0);
    send_frame(8'h82, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, LenForm64, 32'h0);
    // Low length bytes with their top bit set must be taken as unsigned.
    send_frame(8'h82, 1'b0, 64'h0000_0000_8000_0000, LenForm64, 32'h0);
    // The smallest proper 64-bit length is checked against the maximum, not flagged short.
    set_max_length(63'h0FFFF);
    send_frame(8'h82, 1'b1, 64'h0000_0000_0001_0000, LenForm64, $urandom);
  endtask

  task automatic test_limits();
    send_frame(8'h81, 1'b0, 64'd0, LenForm7, 32'h0);
    send_frame(8'h81, 1'b1, 64'd0, LenForm7, 32'hDEADBEEF);
    set_max_length(63'd5);
    send_frame(8'h82, 1'b0, 64'd5, LenForm7, 32'h0);
    send_frame(8'h82, 1'b0, 64'd6, LenForm7, 32'h0);
    send_frame(8'h82, 1'b1, 64'd6, LenForm7, 32'h11223344);
    send_frame(8'h82, 1'b1, 64'd200, LenForm16, 32'h55667788);
    set_max_length(63'd0);
    send_frame(8'h81, 1'b0, 64'd1, LenForm7, 32'h0);
    send_frame(8'h81, 1'b0, 64'd0, LenForm7, 32'h0);
    send_frame(8'h81, 1'b1, 64'd3, LenForm7, 32'hCAFEF00D);
    set_max_length({LenW{1'b1}});
    send_frame(8'h82, 1'b1, 64'd3, LenForm7, $urandom);
    send_frame(8'h82, 1'b0, 64'h8000_0000_0000_0001, LenForm64, 32'h0);
    send_frame(8'h82, 1'b0, 64'hFFFF, LenForm64, 32'h0);
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    rx_bus.valid   = 1'b0;
    rx_bus.rx_byte = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_basic_frames();
    test_header_errors();
    test_length_forms();
    test_limits();

    test_random_traffic(60);
    set_max_length(63'({$urandom, $urandom}));
    test_random_traffic(50);
    set_max_length(63'($urandom_range(20, 150)));
    test_random_traffic(60);
    set_max_length(63'd1);
    test_random_traffic(40);
    set_max_length(63'($urandom_range(40, 300)));
    traffic_idle = 1'b0;
    test_random_traffic(50);

    wait_for_all_results();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("websocket_frame_deframer_top_tb OK");
    end else begin
      $display("websocket_frame_deframer_top_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("websocket_frame_deframer_top_tb NOT OK");
    $finish;
  end

endmodule

### files.f
sv/wsfd_pkg.sv
sv/wsfd_rx_if.sv
sv/wsfd_frame_if.sv
sv/websocket_frame_deframer_top.sv
tb/websocket_frame_deframer_top_tb.sv
